>>> rtl/core/tsg_pkg.sv
// shared types and codes of the touchpad tap and swipe gesture block
`default_nettype none

package tsg_pkg;

  localparam logic [1:0] EV_PRESS   = 2'd0;
  localparam logic [1:0] EV_RELEASE = 2'd1;
  localparam logic [1:0] EV_MOVE    = 2'd2;
  localparam logic [1:0] EV_SCROLL  = 2'd3;

  localparam logic [2:0] CFG_POINTER_SPEED = 3'd0;
  localparam logic [2:0] CFG_DEAD_ZONE     = 3'd1;
  localparam logic [2:0] CFG_RIGHT_CLICK   = 3'd2;
  localparam logic [2:0] CFG_SCROLL        = 3'd3;
  localparam logic [2:0] CFG_INVERT        = 3'd4;

  typedef struct packed {
    logic [7:0]  pointer_speed;
    logic [11:0] dead_zone;
    logic        two_finger_right_click;
    logic        two_finger_scroll;
    logic        invert_scroll;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  contact_count;
    logic [10:0] first_x;
    logic [10:0] first_y;
    logic [10:0] second_y;
    logic [31:0] time_us;
  } frame_t;

  // raw event from the gesture machine, before pointer scaling
  typedef struct packed {
    logic               valid;
    logic [1:0]         kind;
    logic               button;
    logic               neg_x;
    logic               neg_y;
    logic [10:0]        mag_x;
    logic [10:0]        mag_y;
    logic signed [10:0] scroll;
  } pre_t;

endpackage

`default_nettype wire

>>> rtl/core/tsg_frame_if.sv
// touch frame request channel
`default_nettype none

interface tsg_frame_if;
  logic        valid;
  logic        ready;
  logic [2:0]  contact_count;
  logic [10:0] first_x;
  logic [10:0] first_y;
  logic [10:0] second_x;
  logic [10:0] second_y;
  logic [31:0] time_us;

  modport source (
    output valid, contact_count, first_x, first_y, second_x, second_y, time_us,
    input  ready
  );
  modport sink (
    input  valid, contact_count, first_x, first_y, second_x, second_y, time_us,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/core/tsg_event_if.sv
// gesture event request channel
`default_nettype none

interface tsg_event_if;
  logic               valid;
  logic               ready;
  logic [1:0]         event_kind;
  logic               button;
  logic signed [11:0] move_dx;
  logic signed [11:0] move_dy;
  logic signed [10:0] scroll_amount;

  modport source (
    output valid, event_kind, button, move_dx, move_dy, scroll_amount,
    input  ready
  );
  modport sink (
    input  valid, event_kind, button, move_dx, move_dy, scroll_amount,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/core/touchpad_tap_swipe_gesture.sv
// top level of the touchpad tap-to-click and swipe gesture block
`default_nettype none

// Takes one touch frame per clock cycle and gives at most one event per frame:
// button press or release, a scaled pointer move, or a scroll step. The gesture
// state is updated in the cycle a frame is accepted; its event then passes a
// three-register pipeline (decision, speed multiply, divide by 200 through a
// reciprocal multiply) to the event channel. Pointer moves that scale to zero
// are dropped in the last stage. A stalled event channel fills the pipeline and
// then holds off frame requests. Configuration is written through a plain write
// port; users must write only while no frame is in flight; this is not enforced.

module touchpad_tap_swipe_gesture (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [2:0]   cfg_idx_i,
  input  wire logic [11:0]  cfg_data_i,
  tsg_frame_if.sink         frame_i,
  tsg_event_if.source       event_o
);

  localparam logic [7:0]  SPEED_MAX  = 8'd200;
  localparam logic [18:0] ROUND_BIAS = 19'd100;
  // floor(n / 25) = (n * RECIP_25) >> 21 for n below 51200, as the product is 32 bits
  localparam logic [16:0] RECIP_25   = 17'd83887;

  tsg_pkg::cfg_t   cfg_q;
  tsg_pkg::frame_t frame;
  tsg_pkg::pre_t   pre;

  logic accept, out_free, s2_free, s1_free;

  logic          s1_valid_q;
  tsg_pkg::pre_t s1_q;

  logic               s2_valid_q;
  logic [1:0]         s2_kind_q;
  logic               s2_button_q, s2_neg_x_q, s2_neg_y_q;
  logic [18:0]        s2_mx_q, s2_my_q;
  logic signed [10:0] s2_scroll_q;

  logic [7:0]  speed;
  logic [18:0] mx_d, my_d;
  logic [31:0] qx_prod, qy_prod;
  logic [10:0] qx, qy;
  logic        drop;

  logic               ev_valid_q;
  logic [1:0]         ev_kind_q;
  logic               ev_button_q;
  logic signed [11:0] ev_dx_q, ev_dy_q;
  logic signed [10:0] ev_scroll_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pointer_speed          <= 8'd100;
      cfg_q.dead_zone              <= 12'd0;
      cfg_q.two_finger_right_click <= 1'b0;
      cfg_q.two_finger_scroll      <= 1'b0;
      cfg_q.invert_scroll          <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tsg_pkg::CFG_POINTER_SPEED: cfg_q.pointer_speed          <= cfg_data_i[7:0];
        tsg_pkg::CFG_DEAD_ZONE:     cfg_q.dead_zone              <= cfg_data_i;
        tsg_pkg::CFG_RIGHT_CLICK:   cfg_q.two_finger_right_click <= cfg_data_i[0];
        tsg_pkg::CFG_SCROLL:        cfg_q.two_finger_scroll      <= cfg_data_i[0];
        tsg_pkg::CFG_INVERT:        cfg_q.invert_scroll          <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign out_free      = !ev_valid_q || event_o.ready;
  assign s2_free       = !s2_valid_q || out_free;
  assign s1_free       = !s1_valid_q || s2_free;
  assign frame_i.ready = s1_free;
  assign accept        = frame_i.valid && s1_free;

  assign frame.contact_count = frame_i.contact_count;
  assign frame.first_x       = frame_i.first_x;
  assign frame.first_y       = frame_i.first_y;
  assign frame.second_y      = frame_i.second_y;
  assign frame.time_us       = frame_i.time_us;

  tsg_fsm u_fsm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .frame_i  (frame),
    .cfg_i    (cfg_q),
    .pre_o    (pre)
  );

  // decision stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_free) begin
      s1_valid_q <= accept && pre.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_free) begin
      s1_q <= pre;
    end
  end

  // speed multiply stage
  assign speed = (cfg_q.pointer_speed > SPEED_MAX) ? SPEED_MAX : cfg_q.pointer_speed;
  assign mx_d  = 19'(s1_q.mag_x) * 19'(speed) + ROUND_BIAS;
  assign my_d  = 19'(s1_q.mag_y) * 19'(speed) + ROUND_BIAS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_free) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_free) begin
      s2_kind_q   <= s1_q.kind;
      s2_button_q <= s1_q.button;
      s2_neg_x_q  <= s1_q.neg_x;
      s2_neg_y_q  <= s1_q.neg_y;
      s2_mx_q     <= mx_d;
      s2_my_q     <= my_d;
      s2_scroll_q <= s1_q.scroll;
    end
  end

  // divide by 200: drop three bits, then reciprocal of 25
  assign qx_prod = 32'(s2_mx_q[18:3]) * 32'(RECIP_25);
  assign qy_prod = 32'(s2_my_q[18:3]) * 32'(RECIP_25);
  assign qx      = qx_prod[31:21];
  assign qy      = qy_prod[31:21];
  assign drop    = (s2_kind_q == tsg_pkg::EV_MOVE) && (qx == 11'd0) && (qy == 11'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_valid_q <= 1'b0;
    end else if (out_free) begin
      ev_valid_q <= s2_valid_q && !drop;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      ev_kind_q   <= s2_kind_q;
      ev_button_q <= s2_button_q;
      ev_scroll_q <= s2_scroll_q;
      if (s2_kind_q == tsg_pkg::EV_MOVE) begin
        ev_dx_q <= s2_neg_x_q ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
        ev_dy_q <= s2_neg_y_q ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
      end else begin
        ev_dx_q <= 12'sd0;
        ev_dy_q <= 12'sd0;
      end
    end
  end

  assign event_o.valid         = ev_valid_q;
  assign event_o.event_kind    = ev_kind_q;
  assign event_o.button        = ev_button_q;
  assign event_o.move_dx       = ev_dx_q;
  assign event_o.move_dy       = ev_dy_q;
  assign event_o.scroll_amount = ev_scroll_q;

`ifndef ASSERT_OFF
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> frame_i.ready)
    else $error("frame request refused with empty pipeline");

  a_move_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ev_valid_q && ev_kind_q == tsg_pkg::EV_MOVE) |-> (ev_dx_q != 12'sd0 || ev_dy_q != 12'sd0))
    else $error("zero pointer move offered");

  a_scroll_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ev_valid_q && ev_kind_q == tsg_pkg::EV_SCROLL) |-> (ev_scroll_q != 11'sd0))
    else $error("zero scroll step offered");

  a_stall_holds_s2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && !out_free) |=> (s2_valid_q && $stable(s2_mx_q) && $stable(s2_kind_q)))
    else $error("multiply stage lost data under stall");
`endif

endmodule

`default_nettype wire

>>> rtl/core/tsg_fsm.sv
// gesture phase machine: tap, release, swipe and scroll decisions per frame
`default_nettype none

module tsg_fsm (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            accept_i,
  input  wire tsg_pkg::frame_t frame_i,
  input  wire tsg_pkg::cfg_t   cfg_i,
  output tsg_pkg::pre_t        pre_o
);

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_TOUCH  = 2'd1;
  localparam logic [1:0] PH_TAPPED = 2'd2;
  localparam logic [1:0] PH_SWIPE  = 2'd3;

  // elapsed ms <= 250 and elapsed ms > 100, as microsecond bounds
  localparam logic [31:0] TAP_LIMIT_US = 32'd251000;
  localparam logic [31:0] RELEASE_US   = 32'd101000;

  logic [1:0]  phase_q, phase_d;
  logic [2:0]  held_q, held_d;
  logic [31:0] start_q, start_d;
  logic [10:0] origin_x_q, origin_x_d, origin_y_q, origin_y_d;
  logic [10:0] anchor_x_q, anchor_x_d, anchor_y_q, anchor_y_d;
  logic [2:0]  prior_cnt_q;
  logic [10:0] prior_x_q, prior_y_q;

  logic [2:0]         cnt;
  logic [10:0]        fx, fy;
  logic [10:0]        cx, cy, px, py, rx, ry;
  logic [11:0]        dx12, dy12;
  logic [10:0]        mag_x, mag_y;
  logic [11:0]        mv;
  logic               still;
  logic [31:0]        elapsed;
  logic               tap_time, rel_time;
  logic               btn_ok, btn_right;
  logic [11:0]        sum_y;
  logic [10:0]        avg_y;
  logic signed [11:0] sd, sd_half;
  logic signed [10:0] sd_q;
  tsg_pkg::pre_t      pre;

  assign cnt = frame_i.contact_count;
  assign fx  = frame_i.first_x;
  assign fy  = frame_i.first_y;

  // lift frames measure from the previous frame's contact, or from the origin if it had none
  assign cx = (prior_cnt_q != 3'd0) ? prior_x_q : origin_x_q;
  assign cy = (prior_cnt_q != 3'd0) ? prior_y_q : origin_y_q;
  assign px = (cnt == 3'd0) ? cx : fx;
  assign py = (cnt == 3'd0) ? cy : fy;
  assign rx = (phase_q == PH_SWIPE) ? anchor_x_q : origin_x_q;
  assign ry = (phase_q == PH_SWIPE) ? anchor_y_q : origin_y_q;

  assign dx12  = {1'b0, px} - {1'b0, rx};
  assign dy12  = {1'b0, py} - {1'b0, ry};
  assign mag_x = dx12[11] ? 11'(-dx12) : dx12[10:0];
  assign mag_y = dy12[11] ? 11'(-dy12) : dy12[10:0];
  assign mv    = (cnt == 3'd0 && held_q == 3'd0) ? 12'd0
                                                  : {1'b0, mag_x} + {1'b0, mag_y};
  assign still = mv <= cfg_i.dead_zone;

  assign elapsed  = frame_i.time_us - start_q;
  assign tap_time = elapsed < TAP_LIMIT_US;
  assign rel_time = elapsed >= RELEASE_US;

  assign btn_right = held_q == 3'd2;
  assign btn_ok    = (held_q == 3'd1) || (btn_right && cfg_i.two_finger_right_click);

  assign sum_y   = {1'b0, fy} + {1'b0, frame_i.second_y};
  assign avg_y   = sum_y[11:1];
  assign sd      = $signed({1'b0, avg_y} - {1'b0, anchor_y_q});
  // halve rounding toward zero
  assign sd_half = (sd + $signed({11'd0, sd[11]})) >>> 1;
  assign sd_q    = sd_half[10:0];

  always_comb begin
    phase_d    = phase_q;
    held_d     = held_q;
    start_d    = start_q;
    origin_x_d = origin_x_q;
    origin_y_d = origin_y_q;
    anchor_x_d = anchor_x_q;
    anchor_y_d = anchor_y_q;
    pre        = '0;

    if (cnt == 3'd0) begin
      case (phase_q)
        PH_TOUCH: begin
          if (tap_time && still) begin
            pre.valid  = btn_ok;
            pre.kind   = tsg_pkg::EV_PRESS;
            pre.button = btn_right;
            phase_d    = PH_TAPPED;
            start_d    = frame_i.time_us;
          end else begin
            phase_d = PH_IDLE;
            held_d  = 3'd0;
          end
        end
        PH_TAPPED: begin
          if (rel_time) begin
            pre.valid  = btn_ok;
            pre.kind   = tsg_pkg::EV_RELEASE;
            pre.button = btn_right;
            phase_d    = PH_IDLE;
            held_d     = 3'd0;
          end
        end
        default: begin
          phase_d = PH_IDLE;
          held_d  = 3'd0;
        end
      endcase
    end else begin
      case (phase_q)
        PH_IDLE: begin
          phase_d    = PH_TOUCH;
          held_d     = cnt;
          start_d    = frame_i.time_us;
          origin_x_d = fx;
          origin_y_d = fy;
        end
        PH_TOUCH: begin
          if (cnt < held_q) begin
            if (tap_time && still) begin
              pre.valid  = btn_ok;
              pre.kind   = tsg_pkg::EV_PRESS;
              pre.button = btn_right;
              phase_d    = PH_TAPPED;
              start_d    = frame_i.time_us;
            end else begin
              phase_d = PH_IDLE;
            end
          end else if (cnt > held_q) begin
            held_d = cnt;
          end else if (!still) begin
            phase_d = PH_SWIPE;
            if (held_q == 3'd1) begin
              pre.valid  = 1'b1;
              pre.kind   = tsg_pkg::EV_MOVE;
              pre.neg_x  = dx12[11];
              pre.neg_y  = dy12[11];
              pre.mag_x  = mag_x;
              pre.mag_y  = mag_y;
              anchor_x_d = fx;
              anchor_y_d = fy;
            end else if (held_q == 3'd2 && cnt >= 3'd2) begin
              anchor_x_d = fx;
              anchor_y_d = avg_y;
            end
          end
        end
        PH_TAPPED: begin
          if (rel_time) begin
            pre.valid  = btn_ok;
            pre.kind   = tsg_pkg::EV_RELEASE;
            pre.button = btn_right;
            phase_d    = PH_IDLE;
          end
        end
        default: begin
          if (held_q == 3'd1) begin
            pre.valid  = 1'b1;
            pre.kind   = tsg_pkg::EV_MOVE;
            pre.neg_x  = dx12[11];
            pre.neg_y  = dy12[11];
            pre.mag_x  = mag_x;
            pre.mag_y  = mag_y;
            anchor_x_d = fx;
            anchor_y_d = fy;
          end else if (held_q == 3'd2 && cnt >= 3'd2 && cfg_i.two_finger_scroll &&
                       sd_q != 11'sd0) begin
            pre.valid  = 1'b1;
            pre.kind   = tsg_pkg::EV_SCROLL;
            pre.scroll = cfg_i.invert_scroll ? sd_q : -sd_q;
            anchor_y_d = avg_y;
          end
        end
      endcase
    end
  end

  assign pre_o = pre;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      held_q      <= 3'd0;
      start_q     <= 32'd0;
      origin_x_q  <= 11'd0;
      origin_y_q  <= 11'd0;
      anchor_x_q  <= 11'd0;
      anchor_y_q  <= 11'd0;
      prior_cnt_q <= 3'd0;
      prior_x_q   <= 11'd0;
      prior_y_q   <= 11'd0;
    end else if (accept_i) begin
      phase_q     <= phase_d;
      held_q      <= held_d;
      start_q     <= start_d;
      origin_x_q  <= origin_x_d;
      origin_y_q  <= origin_y_d;
      anchor_x_q  <= anchor_x_d;
      anchor_y_q  <= anchor_y_d;
      prior_cnt_q <= cnt;
      if (cnt != 3'd0) begin
        prior_x_q <= fx;
        prior_y_q <= fy;
      end
    end
  end

endmodule

`default_nettype wire
